>>> hdl/vts_pkg.sv
package vts_pkg;

	localparam int TIMER_BITS   = 24;
	localparam int TIMEOUT_BITS = 24;
	localparam int CMP_BITS     = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;

	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(40000);
	localparam logic [TIMER_BITS-1:0]   TIMER_MAX     = {TIMER_BITS{1'b1}};

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_CHECK = 3'd1,
		OP_OPEN  = 3'd2,
		OP_CLOSE = 3'd3,
		OP_STOP  = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ST_STOPPED = 3'd0,
		ST_OPENING = 3'd1,
		ST_CLOSING = 3'd2,
		ST_OPENED  = 3'd3,
		ST_CLOSED  = 3'd4,
		ST_ERROR   = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic       limit_switch;
	} item_t;

	typedef struct packed {
		logic [2:0] valve_status;
		logic       moving;
		logic       at_end;
		logic       faulted;
	} result_t;

	typedef logic [TIMEOUT_BITS-1:0] timeout_t;

endpackage

>>> hdl/vts_intf.sv
interface vts_item_if;
	logic           valid;
	logic           ready;
	vts_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vts_result_if;
	logic             valid;
	logic             ready;
	vts_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface vts_cfg_if;
	logic              valid;
	logic              ready;
	vts_pkg::timeout_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/valve_travel_supervisor.sv
// Valve travel supervisor. Each item beat carries one event (tick, end switch check, open,
// close, stop); the valve status and its derived flags come back one result beat per item,
// in the cycle after acceptance, and a new item is taken every cycle while the result register
// is empty or being drained. The single cfg register is timeout_ticks (reset 40000): travel
// ticks allowed before a check with the end switch not at its target reports error. Write
// it only while the block is idle; a late arrival still ends travel as opened or closed.
module valve_travel_supervisor (
	input  logic           clk,
	input  logic           arst_n,
	vts_item_if.sink       item,
	vts_result_if.source   result,
	vts_cfg_if.sink        cfg
);

	vts_pkg::status_t                   status_q;
	logic [vts_pkg::TIMER_BITS-1:0]     elapsed_q;
	vts_pkg::timeout_t                  timeout_q;
	logic                               res_valid_q;
	vts_pkg::result_t                   res_q;

	logic                               item_fire;
	vts_pkg::status_t                   status_d;
	logic [vts_pkg::TIMER_BITS-1:0]     elapsed_d;
	logic                               moving_now;
	logic                               timed_out;

	assign item.ready = !res_valid_q || result.ready;
	assign item_fire  = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign moving_now = (status_q == vts_pkg::ST_OPENING) || (status_q == vts_pkg::ST_CLOSING);
	assign timed_out  = vts_pkg::CMP_BITS'(elapsed_q) > vts_pkg::CMP_BITS'(timeout_q);

	always_comb begin
		status_d  = status_q;
		elapsed_d = elapsed_q;
		case (item.payload.opcode)
			vts_pkg::OP_TICK: begin
				if (moving_now && elapsed_q != vts_pkg::TIMER_MAX) begin
					elapsed_d = elapsed_q + 1'b1;
				end
			end
			vts_pkg::OP_CHECK: begin
				if (status_q == vts_pkg::ST_OPENING && item.payload.limit_switch) begin
					status_d = vts_pkg::ST_OPENED;
				end else if (status_q == vts_pkg::ST_CLOSING && !item.payload.limit_switch) begin
					status_d = vts_pkg::ST_CLOSED;
				end else if (moving_now && timed_out) begin
					status_d = vts_pkg::ST_ERROR;
				end
			end
			vts_pkg::OP_OPEN: begin
				status_d  = vts_pkg::ST_OPENING;
				elapsed_d = '0;
			end
			vts_pkg::OP_CLOSE: begin
				status_d  = vts_pkg::ST_CLOSING;
				elapsed_d = '0;
			end
			vts_pkg::OP_STOP: begin
				status_d = vts_pkg::ST_STOPPED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= vts_pkg::ST_STOPPED;
			elapsed_q   <= '0;
			timeout_q   <= vts_pkg::TIMEOUT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				timeout_q <= cfg.payload;
			end
			if (item_fire) begin
				status_q  <= status_d;
				elapsed_q <= elapsed_d;
			end
			if (item_fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			res_q.valve_status <= status_d;
			res_q.moving       <= (status_d == vts_pkg::ST_OPENING) ||
			                      (status_d == vts_pkg::ST_CLOSING);
			res_q.at_end       <= (status_d == vts_pkg::ST_OPENED) ||
			                      (status_d == vts_pkg::ST_CLOSED);
			res_q.faulted      <= (status_d == vts_pkg::ST_ERROR);
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> $onehot0({result.payload.moving, result.payload.at_end,
			result.payload.faulted}))
		else $error("result flags not exclusive");

	a_status_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire |=> result.valid && result.payload.valve_status == status_q)
		else $error("result status differs from held status");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && (item.payload.opcode == vts_pkg::OP_OPEN ||
			item.payload.opcode == vts_pkg::OP_CLOSE) |=> elapsed_q == '0)
		else $error("travel timer not cleared on open or close");

	a_idle_timer_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_now && !(item_fire && (item.payload.opcode == vts_pkg::OP_OPEN ||
			item.payload.opcode == vts_pkg::OP_CLOSE)) |=> $stable(elapsed_q))
		else $error("travel timer moved while valve idle");

	a_fault_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.payload.faulted ==
			(result.payload.valve_status == vts_pkg::ST_ERROR))
		else $error("fault flag disagrees with status");

endmodule
